FILE: src/bbqm_pkg.sv
// package: item types, register indexes and constants of the byte budget queue monitor
package bbqm_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int CFG_W = 40;
  localparam int CFG_IDX_W = 2;
  localparam int COST_W = 34;
  localparam int TOTAL_W = 41;
  localparam int PAYLOAD_W = 32;
  localparam logic [COST_W-1:0] PACKET_OVERHEAD = COST_W'(256);

  typedef enum logic [1:0] {
    REQ_POST   = 2'd0,
    REQ_TAKE   = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_FINISH = 2'd3
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK   = CFG_IDX_W'(2);

  typedef struct packed {
    logic [1:0]           req_type;
    logic                 is_data;
    logic [PAYLOAD_W-1:0] value_bytes;
    logic [PAYLOAD_W-1:0] domain_bytes;
    logic                 drop_queued;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               overflowed;
    logic               queue_high;
    logic               state_changed;
    logic               took_entry;
    logic [COST_W-1:0]  took_bytes;
    logic               writer_done;
    logic [TOTAL_W-1:0] queued_total;
    logic               is_finished;
  } out_item_t;

endpackage

FILE: src/byte_budget_queue_monitor_top.sv
// top level: byte budget queue monitor with admission, watermarks and finish handling
// a result passes through the s1 register and then the registered result output
// throughput: one transaction per cycle, set by the state update loop, unless stalled
// the head cost is prefetched from the fifo memory so a take need not wait for it
// reset: synchronous active low, clears flags, counters, pointers and config regs
// payload registers and fifo contents are not cleared; only written entries are used
module byte_budget_queue_monitor_top #(
  parameter int QUEUE_DEPTH = bbqm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bbqm_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bbqm_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [bbqm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbqm_pkg::CFG_W-1:0]       cfg_wdata
);
  import bbqm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CFG_W-1:0]   limit_r, high_mark_r, low_mark_r;

  logic               s1_valid_r, s1_valid_nxt;
  req_t               s1_req_r;
  logic [COST_W-1:0]  s1_cost_r;
  logic               s1_drop_r;
  logic [COST_W-1:0]  in_cost;

  logic [CW-1:0]      count_r, count_nxt;
  logic [PW-1:0]      head_r, head_nxt;
  logic [PW-1:0]      tail_r, tail_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               ovf_r, ovf_nxt;
  logic               high_r, high_nxt;
  logic               stop_r, stop_nxt;
  logic               fin_r, fin_nxt;

  logic               out_valid_r;
  out_item_t          out_r, out_nxt;

  logic               out_load, fire;
  logic               wr_en;
  logic [COST_W-1:0]  head_cost;
  logic [TOTAL_W:0]   sum;
  logic               refuse;
  logic [TOTAL_W-1:0] took_ext;
  logic [TOTAL_W-1:0] drained;

  assign out_load  = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_load;
  assign in_stall  = s1_valid_r && !out_load;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign in_cost = PACKET_OVERHEAD + (in_item.is_data ?
                   (COST_W'(in_item.value_bytes) + COST_W'(in_item.domain_bytes)) : '0);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && !in_stall) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // admission and bookkeeping
  assign sum      = {1'b0, total_r} + (TOTAL_W + 1)'(s1_cost_r);
  assign refuse   = ((limit_r != '0) && (count_r != '0) && (sum > (TOTAL_W + 1)'(limit_r)))
                    || (count_r == CW'(QUEUE_DEPTH)) || sum[TOTAL_W];
  assign took_ext = TOTAL_W'(head_cost);
  assign drained  = (total_r >= took_ext) ? (total_r - took_ext) : '0;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    total_nxt = total_r;
    ovf_nxt   = ovf_r;
    high_nxt  = high_r;
    stop_nxt  = stop_r;
    fin_nxt   = fin_r;
    wr_en     = 1'b0;
    out_nxt   = '0;
    if (fire) begin
      case (s1_req_r)
        REQ_POST: begin
          if (!fin_r && !stop_r && !ovf_r) begin
            if (refuse) begin
              ovf_nxt = 1'b1;
              out_nxt.state_changed = 1'b1;
            end else begin
              wr_en     = 1'b1;
              tail_nxt  = (tail_r == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
              count_nxt = count_r + 1'b1;
              total_nxt = sum[TOTAL_W-1:0];
              out_nxt.accepted = 1'b1;
              if ((limit_r != '0) && !high_r &&
                  (sum[TOTAL_W-1:0] >= TOTAL_W'(high_mark_r))) begin
                high_nxt = 1'b1;
                out_nxt.state_changed = 1'b1;
              end
            end
          end
        end
        REQ_TAKE: begin
          if (count_r != '0) begin
            head_nxt  = (head_r == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
            total_nxt = drained;
            out_nxt.took_entry = 1'b1;
            out_nxt.took_bytes = head_cost;
            if (high_r && (drained <= TOTAL_W'(low_mark_r))) begin
              high_nxt = 1'b0;
              out_nxt.state_changed = 1'b1;
            end
          end else if (stop_r || ovf_r) begin
            out_nxt.writer_done = 1'b1;
            if (ovf_r && !fin_r) begin
              fin_nxt = 1'b1;
              out_nxt.state_changed = 1'b1;
            end
          end
        end
        REQ_STOP: begin
          stop_nxt = 1'b1;
        end
        REQ_FINISH: begin
          if (!fin_r) begin
            fin_nxt = 1'b1;
            out_nxt.state_changed = 1'b1;
            if (s1_drop_r) begin
              count_nxt = '0;
              head_nxt  = '0;
              tail_nxt  = '0;
              total_nxt = '0;
              high_nxt  = 1'b0;
            end
          end
        end
        default: begin
          stop_nxt = stop_r;
        end
      endcase
    end
    out_nxt.overflowed   = ovf_nxt;
    out_nxt.queue_high   = high_nxt;
    out_nxt.queued_total = total_nxt;
    out_nxt.is_finished  = fin_nxt;
  end

  bbqm_cost_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (s1_cost_r),
    .rd_addr (head_nxt),
    .rd_data (head_cost)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '0;
      high_mark_r <= '0;
      low_mark_r  <= '0;
      s1_valid_r  <= 1'b0;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      high_r      <= 1'b0;
      stop_r      <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BYTE_LIMIT: limit_r     <= cfg_wdata;
          CFG_HIGH_MARK:  high_mark_r <= cfg_wdata;
          CFG_LOW_MARK:   low_mark_r  <= cfg_wdata;
          default:        limit_r     <= limit_r;
        endcase
      end
      s1_valid_r <= s1_valid_nxt;
      count_r    <= count_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      total_r    <= total_nxt;
      ovf_r      <= ovf_nxt;
      high_r     <= high_nxt;
      stop_r     <= stop_nxt;
      fin_r      <= fin_nxt;
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r  <= req_t'(in_item.req_type);
      s1_cost_r <= in_cost;
      s1_drop_r <= in_item.drop_queued;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

FILE: src/bbqm_cost_fifo.sv
// cost fifo storage with registered read of the head entry and write bypass
module bbqm_cost_fifo #(
  parameter int DEPTH = bbqm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [bbqm_pkg::COST_W-1:0]           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [bbqm_pkg::COST_W-1:0]           rd_data
);
  import bbqm_pkg::*;

  logic [COST_W-1:0] mem_r [DEPTH];
  logic [COST_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/bbqm_checker.sv
// port-level checker for the byte budget queue monitor and its bind
module bbqm_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input bbqm_pkg::out_item_t     out_item
);
  import bbqm_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // an accepted post always leaves a nonzero total
  a_accept_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.accepted |-> out_item.queued_total != '0)
    else $error("accepted post with zero total");

  // a post is only accepted while open
  a_accept_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.accepted |-> !out_item.overflowed && !out_item.is_finished)
    else $error("post accepted while closed");

  a_took_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.took_entry |-> out_item.took_bytes == '0)
    else $error("took bytes without an entry");

  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.writer_done |-> !out_item.took_entry && !out_item.accepted)
    else $error("writer done with entry activity");

endmodule

bind byte_budget_queue_monitor_top bbqm_checker u_bbqm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
